// ===== design/dda_line_rasterizer_macros.svh =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer_macros.svh
// assertion macros used by the line rasterizer checker
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dda_pkg.sv =====
// ----------------------------------------------------------------------------
// dda_pkg
// types and constants shared by the line rasterizer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dda_pkg;

    // fixed field widths
    localparam int COORD_W  = 21;
    localparam int LEN_W    = 22;
    localparam int STEP_W   = 14;
    localparam int XY_W     = 12;
    localparam int OFF_W    = 26;
    localparam int COLOR_W  = 24;
    localparam int WIN_W    = 13;
    localparam int STRIDE_W = 15;
    localparam int BPP_W    = 6;
    localparam int IN_FRAC  = 8;

    localparam logic [COLOR_W-1:0] RED_COLOR = 24'hFF0000;

    // register reset values
    localparam logic [WIN_W-1:0]    WIN_WIDTH_RST  = 13'd640;
    localparam logic [WIN_W-1:0]    WIN_HEIGHT_RST = 13'd480;
    localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST = 15'd2560;
    localparam logic [BPP_W-1:0]    BPP_RST        = 6'd32;

    // command codes
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_code_t;

    // register indexes
    typedef enum logic [1:0] {
        REG_WIN_WIDTH  = 2'd0,
        REG_WIN_HEIGHT = 2'd1,
        REG_ROW_STRIDE = 2'd2,
        REG_BPP        = 2'd3
    } reg_idx_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic [WIN_W-1:0]    win_width;
        logic [WIN_W-1:0]    win_height;
        logic [STRIDE_W-1:0] row_stride;
        logic [BPP_W-1:0]    bits_per_pixel;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic div_done;
        logic step;
        logic out_clr;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_valid;
    } dp_status_t;

endpackage

// ===== design/dda_ctrl.sv =====
// ----------------------------------------------------------------------------
// dda_ctrl
// sequencer: accepts words, runs the increment divider, issues steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_ctrl
    import dda_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  logic       cmd,
    output logic       cmd_stall,
    input  logic       res_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  ctl
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             can_take;

    // state and divide counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        can_take   = !(status.out_valid && res_stall);
        cmd_stall  = 1'b1;
        ctl.out_clr = status.out_valid && !res_stall;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = !can_take;
                if (cmd_valid && can_take)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        ctl.load   = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        ctl.step = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    ctl.div_done = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/dda_datapath.sv =====
// ----------------------------------------------------------------------------
// dda_datapath
// line setup, radix-2 increment divider, position stepping and result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_datapath
    import dda_pkg::*;
#(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_cmd_t                 ctl,
    output dp_status_t                status,
    input  cfg_t                      cfg,
    input  logic signed [COORD_W-1:0] start_x,
    input  logic signed [COORD_W-1:0] start_y,
    input  logic signed [COORD_W-1:0] end_x,
    input  logic signed [COORD_W-1:0] end_y,
    output logic                      res_valid,
    output logic                      pixel_valid,
    output logic [XY_W-1:0]           pixel_x,
    output logic [XY_W-1:0]           pixel_y,
    output logic [OFF_W-1:0]          byte_offset,
    output logic [COLOR_W-1:0]        color,
    output logic                      last_pixel
);

    localparam int CUR_W  = FRAC_BITS + COORD_W;
    localparam int IP_W   = CUR_W - 1 - FRAC_BITS;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int INC_W  = FRAC_BITS + 2;
    localparam int PX_W   = $clog2(MAX_DIM);
    localparam int PROD_W = PX_W + STRIDE_W;
    localparam int SHL    = FRAC_BITS - IN_FRAC;
    localparam logic [IP_W-1:0] MAX_DIM_I = IP_W'(MAX_DIM);

    // line state
    logic signed [CUR_W-1:0] cur_x_reg, cur_y_reg;
    logic signed [INC_W-1:0] inc_x_reg, inc_y_reg;
    logic [STEP_W-1:0]       steps_reg;
    logic                    active_reg;

    // divider state
    logic [LEN_W-1:0] len_reg, rx_reg, ry_reg;
    logic [Q_W-1:0]   qx_reg, qy_reg;
    logic             fx_reg, fy_reg, sgnx_reg, sgny_reg;

    // result word
    logic               ov_reg, pv_reg, last_reg;
    logic [XY_W-1:0]    px_reg, py_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [COLOR_W-1:0] color_reg;

    // load setup
    logic signed [LEN_W-1:0] dx, dy;
    logic [LEN_W-1:0]        ax, ay, len;
    logic [LEN_W-1:0]        len_rnd;
    logic [STEP_W-1:0]       cnt;

    always_comb
    begin
        dx      = LEN_W'(end_x) - LEN_W'(start_x);
        dy      = LEN_W'(end_y) - LEN_W'(start_y);
        ax      = dx[LEN_W-1] ? LEN_W'(-dx) : LEN_W'(dx);
        ay      = dy[LEN_W-1] ? LEN_W'(-dy) : LEN_W'(dy);
        len     = (ax >= ay) ? ax : ay;
        len_rnd = len + LEN_W'(255);
        cnt     = len_rnd[LEN_W-1:IN_FRAC];
    end

    // one quotient bit per cycle for each axis
    logic [LEN_W:0]   tx, ty;
    logic             gex, gey;
    logic [LEN_W-1:0] rx_next, ry_next;
    logic [Q_W-1:0]   qx_next, qy_next;

    always_comb
    begin
        tx      = {rx_reg, fx_reg};
        ty      = {ry_reg, fy_reg};
        gex     = tx >= {1'b0, len_reg};
        gey     = ty >= {1'b0, len_reg};
        rx_next = gex ? LEN_W'(tx - {1'b0, len_reg}) : tx[LEN_W-1:0];
        ry_next = gey ? LEN_W'(ty - {1'b0, len_reg}) : ty[LEN_W-1:0];
        qx_next = {qx_reg[Q_W-2:0], gex};
        qy_next = {qy_reg[Q_W-2:0], gey};
    end

    // pixel of the current position
    logic [IP_W-1:0]    ix, iy, bx, by;
    logic               in_win;
    logic [PX_W-1:0]    px_m, py_m;
    logic [PROD_W-1:0]  prod_y;
    logic [BPP_W-4:0]   bytes_pp;
    logic [PX_W+2:0]    prod_x;
    logic [OFF_W-1:0]   off;

    always_comb
    begin
        ix       = cur_x_reg[CUR_W-2:FRAC_BITS];
        iy       = cur_y_reg[CUR_W-2:FRAC_BITS];
        bx       = (IP_W'(cfg.win_width) < MAX_DIM_I) ? IP_W'(cfg.win_width) : MAX_DIM_I;
        by       = (IP_W'(cfg.win_height) < MAX_DIM_I) ? IP_W'(cfg.win_height) : MAX_DIM_I;
        in_win   = active_reg && !cur_x_reg[CUR_W-1] && !cur_y_reg[CUR_W-1]
                   && (ix < bx) && (iy < by);
        px_m     = ix[PX_W-1:0];
        py_m     = iy[PX_W-1:0];
        bytes_pp = cfg.bits_per_pixel[BPP_W-1:3];
        prod_y   = py_m * cfg.row_stride;
        prod_x   = px_m * bytes_pp;
        off      = OFF_W'(prod_y) + OFF_W'(prod_x);
    end

    // control state of the line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            steps_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                active_reg <= 1'b0;
                steps_reg  <= cnt;
            end
            else if (ctl.div_done)
            begin
                active_reg <= (steps_reg != '0);
            end
            else if (ctl.step)
            begin
                if (in_win)
                begin
                    steps_reg  <= steps_reg - 1'b1;
                    active_reg <= (steps_reg != STEP_W'(1));
                end
                else
                begin
                    steps_reg  <= '0;
                    active_reg <= 1'b0;
                end
            end
            if (ctl.step)
                ov_reg <= 1'b1;
            else if (ctl.out_clr)
                ov_reg <= 1'b0;
        end
    end

    // position, increments and divider
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cur_x_reg <= CUR_W'(start_x) <<< SHL;
            cur_y_reg <= CUR_W'(start_y) <<< SHL;
            len_reg   <= len;
            rx_reg    <= ax >> 1;
            ry_reg    <= ay >> 1;
            fx_reg    <= ax[0];
            fy_reg    <= ay[0];
            qx_reg    <= '0;
            qy_reg    <= '0;
            sgnx_reg  <= dx[LEN_W-1];
            sgny_reg  <= dy[LEN_W-1];
        end
        else if (ctl.div_step)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            fx_reg <= 1'b0;
            fy_reg <= 1'b0;
            qx_reg <= qx_next;
            qy_reg <= qy_next;
        end
        else if (ctl.step && in_win)
        begin
            cur_x_reg <= cur_x_reg + {{(CUR_W-INC_W){inc_x_reg[INC_W-1]}}, inc_x_reg};
            cur_y_reg <= cur_y_reg + {{(CUR_W-INC_W){inc_y_reg[INC_W-1]}}, inc_y_reg};
        end
        // the last quotient bit lands in the same cycle
        if (ctl.div_done)
        begin
            inc_x_reg <= sgnx_reg ? -{1'b0, qx_next} : {1'b0, qx_next};
            inc_y_reg <= sgny_reg ? -{1'b0, qy_next} : {1'b0, qy_next};
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            pv_reg    <= in_win;
            px_reg    <= in_win ? ix[XY_W-1:0] : '0;
            py_reg    <= in_win ? iy[XY_W-1:0] : '0;
            off_reg   <= in_win ? off : '0;
            color_reg <= in_win ? RED_COLOR : '0;
            last_reg  <= in_win && (steps_reg == STEP_W'(1));
        end
    end

    assign status.out_valid = ov_reg;
    assign res_valid        = ov_reg;
    assign pixel_valid      = pv_reg;
    assign pixel_x          = px_reg;
    assign pixel_y          = py_reg;
    assign byte_offset      = off_reg;
    assign color            = color_reg;
    assign last_pixel       = last_reg;

endmodule

// ===== design/dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// fixed-point DDA line rasterizer with APB register port
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  command   cmd_valid / cmd_stall  cmd, start_x, start_y, end_x, end_y
//  result    res_valid / res_stall  pixel_valid, pixel_x, pixel_y,
//                                   byte_offset, color, last_pixel
//  config    APB psel/penable       paddr, pwdata, prdata
//
//  step words stream at one per cycle while res_stall is low
//  a load word runs the radix-2 increment divider
//  a load gives no result word; cmd_stall is high while the divider runs
//  a held result word stalls new words only while res_stall is high
//  rst_n clears the line state and sets the registers to their defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // apb
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // command words
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  logic                      cmd,
    input  logic signed [COORD_W-1:0] start_x,
    input  logic signed [COORD_W-1:0] start_y,
    input  logic signed [COORD_W-1:0] end_x,
    input  logic signed [COORD_W-1:0] end_y,
    // result words
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic                      pixel_valid,
    output logic [XY_W-1:0]           pixel_x,
    output logic [XY_W-1:0]           pixel_y,
    output logic [OFF_W-1:0]          byte_offset,
    output logic [COLOR_W-1:0]        color,
    output logic                      last_pixel
);

    cfg_t       cfg_reg;
    ctrl_cmd_t  ctl;
    dp_status_t status;
    logic       wr_en;
    reg_idx_t   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[3:2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_width      <= WIN_WIDTH_RST;
            cfg_reg.win_height     <= WIN_HEIGHT_RST;
            cfg_reg.row_stride     <= ROW_STRIDE_RST;
            cfg_reg.bits_per_pixel <= BPP_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_WIN_WIDTH:  cfg_reg.win_width      <= pwdata[WIN_W-1:0];
                REG_WIN_HEIGHT: cfg_reg.win_height     <= pwdata[WIN_W-1:0];
                REG_ROW_STRIDE: cfg_reg.row_stride     <= pwdata[STRIDE_W-1:0];
                REG_BPP:        cfg_reg.bits_per_pixel <= pwdata[BPP_W-1:0];
                default:        ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (idx)
            REG_WIN_WIDTH:  prdata = 32'(cfg_reg.win_width);
            REG_WIN_HEIGHT: prdata = 32'(cfg_reg.win_height);
            REG_ROW_STRIDE: prdata = 32'(cfg_reg.row_stride);
            REG_BPP:        prdata = 32'(cfg_reg.bits_per_pixel);
            default:        prdata = '0;
        endcase
    end

    dda_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_stall (cmd_stall),
        .res_stall (res_stall),
        .status    (status),
        .ctl       (ctl)
    );

    dda_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .status      (status),
        .cfg         (cfg_reg),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .res_valid   (res_valid),
        .pixel_valid (pixel_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .byte_offset (byte_offset),
        .color       (color),
        .last_pixel  (last_pixel)
    );

endmodule

// ===== design/dda_checker.sv =====
// ----------------------------------------------------------------------------
// dda_checker
// port-level checks for the line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dda_line_rasterizer_macros.svh"

module dda_checker
    import dda_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input logic               cmd,
    input logic               res_valid,
    input logic               res_stall,
    input logic               pixel_valid,
    input logic [XY_W-1:0]    pixel_x,
    input logic [XY_W-1:0]    pixel_y,
    input logic [OFF_W-1:0]   byte_offset,
    input logic [COLOR_W-1:0] color,
    input logic               last_pixel
);

    // an empty word carries all-zero fields
    `DDA_ASSERT_NOW(a_empty_zero, res_valid && !pixel_valid, pixel_x == '0 && pixel_y == '0 && byte_offset == '0 && color == '0 && !last_pixel, "empty word has nonzero fields")

    // an emitted pixel is red
    `DDA_ASSERT_NOW(a_pixel_red, res_valid && pixel_valid, color == RED_COLOR, "pixel color is not red")

    // a load word starts the divider, which holds off the next word
    `DDA_ASSERT_NEXT(a_load_busy, cmd_valid && !cmd_stall && cmd == CMD_LOAD, cmd_stall, "no stall after load")

    // every accepted step word shows a result word the next cycle
    `DDA_ASSERT_NEXT(a_step_result, cmd_valid && !cmd_stall && cmd == CMD_STEP, res_valid, "step word without result")

    // a stalled result word holds
    `DDA_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(pixel_x) && $stable(byte_offset), "stalled result changed")

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (.*);
